[sv/pstr_pkg.sv]
// Shared constants and types for the perimeter span to rectangles block.
`timescale 1ns / 1ps

package pstr_pkg;

   // Widths of the request and response fields.
   localparam int IN_W    = 12;
   localparam int COORD_W = 8;
   localparam int RUN_W   = 3;

   // Outline layout: five runs, up to three pieces per request.
   localparam int RUN_COUNT   = 5;
   localparam int PIECE_COUNT = 3;
   localparam int SLOT_COUNT  = PIECE_COUNT * RUN_COUNT;

   // Piece slots, in the order they are emitted.
   localparam int PIECE_HEAD = 0;
   localparam int PIECE_TAIL = 1;
   localparam int PIECE_MAIN = 2;

   // Per-run direction flags, bit r belongs to run r.
   localparam logic [RUN_COUNT-1:0] RUN_HORIZ = 5'b10101;
   localparam logic [RUN_COUNT-1:0] RUN_UP    = 5'b10011;

   // One finished rectangle.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [RUN_W-1:0]   run;
      logic               last;
   } rect_type;

endpackage

[sv/perimeter_span_to_rects.sv]
// Top level: turns a stretch of outline positions into band fill rectangles.
`timescale 1ns / 1ps

//  channel   ports                               handshake
//  request   req_from_pos, req_to_pos            start & !busy
//  response  rsp_rect_x/y/w/h, rsp_run_index,    rsp_valid, one cycle each
//            rsp_last
//
// A request is registered and cut into up to three pieces (head, tail, main),
// each clipped against the five runs: fifteen slots in all.
// One rectangle leaves per cycle from the slot select logic, so the rectangles of a
// request leave one after another. The pieces and pending slots are registered at
// acceptance, and each selected rectangle is registered again before the ports.
// busy is high while more than one rectangle of the current request remains,
// so the next request is taken in the cycle its predecessor's last rectangle goes.
// Reset is synchronous and clears the pending slots and the response strobe.
// The receiver cannot stall: each result is on the ports for exactly one cycle.

module perimeter_span_to_rects
   import pstr_pkg::*;
#(
   parameter int SCREEN_WIDTH   = 144,
   parameter int SCREEN_HEIGHT  = 168,
   parameter int BAND_THICKNESS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [IN_W-1:0]    req_from_pos,
   input  logic signed [IN_W-1:0]    req_to_pos,
   output logic                      rsp_valid,
   output logic [COORD_W-1:0]        rsp_rect_x,
   output logic [COORD_W-1:0]        rsp_rect_y,
   output logic [COORD_W-1:0]        rsp_rect_w,
   output logic [COORD_W-1:0]        rsp_rect_h,
   output logic [RUN_W-1:0]          rsp_run_index,
   output logic                      rsp_last
);

   localparam int PERIM_LEN = 2 * SCREEN_WIDTH + 2 * SCREEN_HEIGHT;
   localparam int POS_W     = $clog2((1 << (IN_W - 1)) + PERIM_LEN + 1) + 1;
   localparam int HALF_W    = SCREEN_WIDTH / 2;

   localparam logic signed [POS_W-1:0] PERIM = POS_W'(PERIM_LEN);
   localparam logic signed [POS_W-1:0] ZERO  = POS_W'(0);
   localparam logic [COORD_W-1:0]      BAND  = COORD_W'(BAND_THICKNESS);

   // Run table: where each run opens, its length, band edge and start coordinate.
   localparam logic signed [POS_W-1:0] RUN_BASE [RUN_COUNT] = '{
      POS_W'(0),
      POS_W'(HALF_W),
      POS_W'(HALF_W + SCREEN_HEIGHT),
      POS_W'(HALF_W + SCREEN_HEIGHT + SCREEN_WIDTH),
      POS_W'(HALF_W + 2 * SCREEN_HEIGHT + SCREEN_WIDTH)
   };
   localparam logic signed [POS_W-1:0] RUN_LEN [RUN_COUNT] = '{
      POS_W'(HALF_W),
      POS_W'(SCREEN_HEIGHT),
      POS_W'(SCREEN_WIDTH),
      POS_W'(SCREEN_HEIGHT),
      POS_W'(HALF_W)
   };
   localparam logic signed [POS_W-1:0] RUN_EDGE [RUN_COUNT] = '{
      POS_W'(0),
      POS_W'(SCREEN_WIDTH - BAND_THICKNESS),
      POS_W'(SCREEN_HEIGHT - BAND_THICKNESS),
      POS_W'(0),
      POS_W'(0)
   };
   localparam logic signed [POS_W-1:0] RUN_ORIGIN [RUN_COUNT] = '{
      POS_W'(HALF_W),
      POS_W'(0),
      POS_W'(SCREEN_WIDTH),
      POS_W'(SCREEN_HEIGHT),
      POS_W'(0)
   };

   logic signed [POS_W-1:0] piece_from_ff [PIECE_COUNT];
   logic signed [POS_W-1:0] piece_to_ff   [PIECE_COUNT];
   logic signed [POS_W-1:0] piece_from_in [PIECE_COUNT];
   logic signed [POS_W-1:0] piece_to_in   [PIECE_COUNT];
   logic [SLOT_COUNT-1:0]   pend_ff;
   logic [SLOT_COUNT-1:0]   pend_in;

   logic signed [POS_W-1:0] slot_lo [SLOT_COUNT];
   logic signed [POS_W-1:0] slot_hi [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]   slot_hit;
   logic [SLOT_COUNT-1:0]   live;
   logic [SLOT_COUNT-1:0]   pick;
   logic [SLOT_COUNT-1:0]   remain;
   logic [RUN_COUNT-1:0]    run_sel;
   logic [RUN_W-1:0]        run_idx;
   logic signed [POS_W-1:0] sel_lo;
   logic signed [POS_W-1:0] sel_hi;
   logic signed [POS_W-1:0] sel_edge;
   logic signed [POS_W-1:0] sel_origin;
   logic                    sel_horiz;
   logic                    sel_up;
   logic signed [POS_W-1:0] low_pos;
   logic signed [POS_W-1:0] span;
   logic                    accept;

   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rect_type rect_ff;
   rect_type rect_in;

   // Split the incoming stretch into head, tail and main pieces.
   always_comb begin
      logic signed [POS_W-1:0] from_x;
      logic signed [POS_W-1:0] to_x;
      from_x = POS_W'(req_from_pos);
      to_x   = POS_W'(req_to_pos);
      // Head wraps the part below zero to the end of the outline.
      if (from_x < ZERO) begin
         piece_from_in[PIECE_HEAD] = from_x + PERIM;
         piece_to_in[PIECE_HEAD]   = PERIM;
      end else begin
         piece_from_in[PIECE_HEAD] = ZERO;
         piece_to_in[PIECE_HEAD]   = ZERO;
      end
      // Tail wraps the part past the perimeter to the start.
      if (to_x > PERIM) begin
         piece_from_in[PIECE_TAIL] = ZERO;
         piece_to_in[PIECE_TAIL]   = to_x - PERIM;
      end else begin
         piece_from_in[PIECE_TAIL] = ZERO;
         piece_to_in[PIECE_TAIL]   = ZERO;
      end
      piece_from_in[PIECE_MAIN] = (from_x < ZERO) ? ZERO : from_x;
      piece_to_in[PIECE_MAIN]   = (to_x > PERIM) ? PERIM : to_x;
   end

   // Clip every piece against every run, all slots side by side.
   always_comb begin
      logic signed [POS_W-1:0] lo;
      logic signed [POS_W-1:0] hi;
      for (int pc = 0; pc < PIECE_COUNT; pc++) begin
         for (int r = 0; r < RUN_COUNT; r++) begin
            lo = piece_from_ff[pc] - RUN_BASE[r];
            hi = piece_to_ff[pc] - RUN_BASE[r];
            if (lo < ZERO) begin
               lo = ZERO;
            end
            if (hi > RUN_LEN[r]) begin
               hi = RUN_LEN[r];
            end
            slot_lo[pc * RUN_COUNT + r]  = lo;
            slot_hi[pc * RUN_COUNT + r]  = hi;
            slot_hit[pc * RUN_COUNT + r] = hi > lo;
         end
      end
   end

   // Take the earliest slot still owed a rectangle.
   assign live   = pend_ff & slot_hit;
   assign pick   = live & (~live + SLOT_COUNT'(1));
   assign remain = live & ~pick;
   assign busy   = |remain;
   assign accept = start & ~busy;

   // Steer the chosen slot's extent and its run's description.
   always_comb begin
      sel_lo = ZERO;
      sel_hi = ZERO;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (pick[s]) begin
            sel_lo = sel_lo | slot_lo[s];
            sel_hi = sel_hi | slot_hi[s];
         end
      end
      run_sel = '0;
      for (int pc = 0; pc < PIECE_COUNT; pc++) begin
         run_sel = run_sel | pick[pc * RUN_COUNT +: RUN_COUNT];
      end
      run_idx    = '0;
      sel_edge   = ZERO;
      sel_origin = ZERO;
      for (int r = 0; r < RUN_COUNT; r++) begin
         if (run_sel[r]) begin
            run_idx    = run_idx | RUN_W'(r);
            sel_edge   = sel_edge | RUN_EDGE[r];
            sel_origin = sel_origin | RUN_ORIGIN[r];
         end
      end
      sel_horiz = |(run_sel & RUN_HORIZ);
      sel_up    = |(run_sel & RUN_UP);
   end

   // Rectangle geometry: runs that count down start at the far end.
   always_comb begin
      span    = sel_hi - sel_lo;
      low_pos = sel_up ? (sel_origin + sel_lo) : (sel_origin - sel_hi);
      rect_in.run  = run_idx;
      rect_in.last = ~busy;
      if (sel_horiz) begin
         rect_in.x = low_pos[COORD_W-1:0];
         rect_in.y = sel_edge[COORD_W-1:0];
         rect_in.w = span[COORD_W-1:0];
         rect_in.h = BAND;
      end else begin
         rect_in.x = sel_edge[COORD_W-1:0];
         rect_in.y = low_pos[COORD_W-1:0];
         rect_in.w = BAND;
         rect_in.h = span[COORD_W-1:0];
      end
      rsp_valid_in = |live;
   end

   // A new request reloads every slot; otherwise the emitted one is retired.
   assign pend_in = accept ? {SLOT_COUNT{1'b1}} : remain;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         piece_from_ff <= piece_from_in;
         piece_to_ff   <= piece_to_in;
      end
      rect_ff <= rect_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rect_x    = rect_ff.x;
   assign rsp_rect_y    = rect_ff.y;
   assign rsp_rect_w    = rect_ff.w;
   assign rsp_rect_h    = rect_ff.h;
   assign rsp_run_index = rect_ff.run;
   assign rsp_last      = rect_ff.last;

   // A response that is not the last is always followed by another.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("response train broken before its last rectangle");

   // While busy, the rectangle leaving now cannot be the request's last.
   assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !rsp_last)
      else $error("busy without a following non-final response");

   // Run index always names one of the five runs.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_index <= RUN_W'(RUN_COUNT - 1))
      else $error("run index out of range");

endmodule

[verif/tb_perimeter_span_to_rects.sv]
// Self-checking testbench for the perimeter span to rectangles block.
`timescale 1ns / 1ps

module tb_perimeter_span_to_rects
   import pstr_pkg::*;
;

   localparam int SCR_W      = 144;
   localparam int SCR_H      = 168;
   localparam int BAND       = 6;
   localparam int OUTLINE    = 2 * SCR_W + 2 * SCR_H;
   localparam int CYCLE_CAP  = 200000;
   localparam int TAIL_WAIT  = 20;
   localparam int PRINT_CAP  = 60;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [IN_W-1:0]   req_from_pos;
   logic signed [IN_W-1:0]   req_to_pos;
   logic                     rsp_valid;
   logic [COORD_W-1:0]       rsp_rect_x;
   logic [COORD_W-1:0]       rsp_rect_y;
   logic [COORD_W-1:0]       rsp_rect_w;
   logic [COORD_W-1:0]       rsp_rect_h;
   logic [RUN_W-1:0]         rsp_run_index;
   logic                     rsp_last;

   // Rectangles still owed by the block, oldest first.
   rect_type expected_rects[$];

   int error_count   = 0;
   int spans_sent    = 0;
   int rects_checked = 0;
   int cycle_count   = 0;

   perimeter_span_to_rects #(
      .SCREEN_WIDTH   (SCR_W),
      .SCREEN_HEIGHT  (SCR_H),
      .BAND_THICKNESS (BAND)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_from_pos  (req_from_pos),
      .req_to_pos    (req_to_pos),
      .rsp_valid     (rsp_valid),
      .rsp_rect_x    (rsp_rect_x),
      .rsp_rect_y    (rsp_rect_y),
      .rsp_rect_w    (rsp_rect_w),
      .rsp_rect_h    (rsp_rect_h),
      .rsp_run_index (rsp_run_index),
      .rsp_last      (rsp_last)
   );

   // Free-running clock with a 10 ns period.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Prints one line per problem, up to a cap, and counts every one.
   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Clips the stretch [lo, hi) against the five outline runs and queues one
   // rectangle per non-empty overlap. Returns how many were queued.
   function automatic int clip_span(input int lo, input int hi);
      int       base, len, edge_pos, origin, dir;
      bit       horiz;
      int       a, b, p, q, low, span, count;
      rect_type rect;
      count = 0;
      for (int r = 0; r < RUN_COUNT; r++) begin
         case (r)
            0: begin
               base = 0; len = SCR_W / 2; horiz = 1'b1;
               edge_pos = 0; origin = SCR_W / 2; dir = 1;
            end
            1: begin
               base = SCR_W / 2; len = SCR_H; horiz = 1'b0;
               edge_pos = SCR_W - BAND; origin = 0; dir = 1;
            end
            2: begin
               base = SCR_W / 2 + SCR_H; len = SCR_W; horiz = 1'b1;
               edge_pos = SCR_H - BAND; origin = SCR_W; dir = -1;
            end
            3: begin
               base = SCR_W / 2 + SCR_H + SCR_W; len = SCR_H; horiz = 1'b0;
               edge_pos = 0; origin = SCR_H; dir = -1;
            end
            default: begin
               base = SCR_W / 2 + 2 * SCR_H + SCR_W; len = SCR_W / 2; horiz = 1'b1;
               edge_pos = 0; origin = 0; dir = 1;
            end
         endcase
         a = lo - base;
         b = hi - base;
         if (a < 0) a = 0;
         if (b > len) b = len;
         if (b <= a) continue;
         p    = origin + dir * a;
         q    = origin + dir * b;
         low  = (p < q) ? p : q;
         span = (p < q) ? q - p : p - q;
         rect.x    = horiz ? low[7:0] : edge_pos[7:0];
         rect.y    = horiz ? edge_pos[7:0] : low[7:0];
         rect.w    = horiz ? span[7:0] : BAND[7:0];
         rect.h    = horiz ? BAND[7:0] : span[7:0];
         rect.run  = r[RUN_W-1:0];
         rect.last = 1'b0;
         expected_rects.push_back(rect);
         count++;
      end
      return count;
   endfunction

   // Works out every rectangle of one request: head, tail, then main piece.
   function automatic void predict_rects(input logic signed [IN_W-1:0] from_pos,
                                         input logic signed [IN_W-1:0] to_pos);
      int       lo, hi, n;
      rect_type final_rect;
      lo = int'(from_pos);
      hi = int'(to_pos);
      n  = 0;
      if (lo < 0) begin
         n  = n + clip_span(lo + OUTLINE, OUTLINE);
         lo = 0;
      end
      if (hi > OUTLINE) begin
         n  = n + clip_span(0, hi - OUTLINE);
         hi = OUTLINE;
      end
      n = n + clip_span(lo, hi);
      // The final rectangle of the request carries the last flag.
      if (n > 0) begin
         final_rect = expected_rects.pop_back();
         final_rect.last = 1'b1;
         expected_rects.push_back(final_rect);
      end
   endfunction

   // Drives one request, waits for it to be taken, then idles for the requested gap.
   task automatic send_span(input int from_v, input int to_v, input int gap);
      @(negedge clock);
      start        <= 1'b1;
      req_from_pos <= from_v[IN_W-1:0];
      req_to_pos   <= to_v[IN_W-1:0];
      do
         @(posedge clock);
      while (busy);
      predict_rects(req_from_pos, req_to_pos);
      spans_sent++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Mostly short gaps, sometimes a long one.
   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Holds the sender off until every owed rectangle has come out.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_rects.size() != 0) @(posedge clock);
   endtask

   // Random stretch: mostly plausible spans, plus boundary hits and noise.
   task automatic pick_span(output int from_v, output int to_v);
      int                     k;
      logic signed [IN_W-1:0] raw;
      k = $urandom_range(0, 99);
      if (k < 55) begin
         from_v = int'($urandom_range(0, 724)) - 100;
         if ($urandom_range(0, 1))
            to_v = from_v + int'($urandom_range(0, 80));
         else
            to_v = from_v + int'($urandom_range(0, 700));
      end else if (k < 72) begin
         case ($urandom_range(0, 5))
            0: from_v = 0;
            1: from_v = SCR_W / 2;
            2: from_v = SCR_W / 2 + SCR_H;
            3: from_v = SCR_W / 2 + SCR_H + SCR_W;
            4: from_v = SCR_W / 2 + 2 * SCR_H + SCR_W;
            default: from_v = OUTLINE;
         endcase
         from_v = from_v + int'($urandom_range(0, 6)) - 3;
         to_v   = from_v + int'($urandom_range(0, 250));
      end else if (k < 90) begin
         from_v = int'($urandom_range(0, 1872)) - 624;
         to_v   = int'($urandom_range(0, 1872)) - 624;
      end else begin
         raw    = IN_W'($urandom);
         from_v = int'(raw);
         raw    = IN_W'($urandom);
         to_v   = int'(raw);
      end
   endtask

   // Compares every result with the oldest owed rectangle.
   always @(posedge clock) begin
      rect_type want;
      if (!reset && rsp_valid) begin
         if (expected_rects.size() == 0) begin
            report_error($sformatf("unexpected rectangle x=%0d y=%0d w=%0d h=%0d run=%0d",
                                   rsp_rect_x, rsp_rect_y, rsp_rect_w, rsp_rect_h,
                                   rsp_run_index));
         end else begin
            want = expected_rects.pop_front();
            rects_checked++;
            if (rsp_rect_x !== want.x)
               report_error($sformatf("rect_x %0d, want %0d", rsp_rect_x, want.x));
            if (rsp_rect_y !== want.y)
               report_error($sformatf("rect_y %0d, want %0d", rsp_rect_y, want.y));
            if (rsp_rect_w !== want.w)
               report_error($sformatf("rect_w %0d, want %0d", rsp_rect_w, want.w));
            if (rsp_rect_h !== want.h)
               report_error($sformatf("rect_h %0d, want %0d", rsp_rect_h, want.h));
            if (rsp_run_index !== want.run)
               report_error($sformatf("run_index %0d, want %0d", rsp_run_index, want.run));
            if (rsp_last !== want.last)
               report_error($sformatf("last %0b, want %0b", rsp_last, want.last));
         end
      end
   end

   // Each run on its own, one-position pieces at run joins, and the whole outline.
   task automatic test_single_runs();
      send_span(0, 72, pick_gap());
      send_span(72, 240, pick_gap());
      send_span(240, 384, pick_gap());
      send_span(384, 552, pick_gap());
      send_span(552, 624, pick_gap());
      send_span(71, 73, pick_gap());
      send_span(0, 1, pick_gap());
      send_span(623, 624, pick_gap());
      send_span(0, OUTLINE, pick_gap());
   endtask

   // Empty and reversed stretches give nothing.
   task automatic test_empty_spans();
      send_span(100, 100, 0);
      send_span(500, 10, 0);
      send_span(0, 0, 1);
      send_span(OUTLINE, OUTLINE, 2);
   endtask

   // Wrapped head and tail pieces, including the fifteen-rectangle case.
   task automatic test_wrapped_spans();
      send_span(-10, 10, pick_gap());
      send_span(600, 650, pick_gap());
      send_span(-1, OUTLINE + 1, pick_gap());
      send_span(-OUTLINE, 2 * OUTLINE, 0);
      send_span(-2048, 2047, 0);
   endtask

   // Field extremes, far outside the outline.
   task automatic test_field_extremes();
      send_span(2047, -2048, 1);
      send_span(-2048, 0, 0);
      send_span(0, 2047, 0);
      send_span(-2048, -2048, 3);
      send_span(2047, 2047, pick_gap());
   endtask

   // Random stretches with random gaps; the sender drains now and then.
   task automatic test_random_spans(input int count);
      int f, t;
      for (int i = 0; i < count; i++) begin
         pick_span(f, t);
         send_span(f, t, pick_gap());
         if (i % 60 == 59) wait_drained();
      end
   endtask

   // Requests back to back, with start held high between them.
   task automatic test_back_to_back(input int count);
      int f, t;
      for (int i = 0; i < count; i++) begin
         pick_span(f, t);
         send_span(f, t, 0);
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_from_pos = '0;
      req_to_pos   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_runs();
      test_empty_spans();
      test_wrapped_spans();
      test_field_extremes();
      wait_drained();
      test_random_spans(200);
      test_back_to_back(50);

      // Let the last request finish, then watch for stray results.
      @(negedge clock);
      start <= 1'b0;
      while (expected_rects.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      $display("Sent %0d stretches (directed runs, joins, empty, wrapped, extremes, random).",
               spans_sent);
      $display("Checked %0d rectangles, %0d errors.", rects_checked, error_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
sv/pstr_pkg.sv
sv/perimeter_span_to_rects.sv
verif/tb_perimeter_span_to_rects.sv
